### sv/kvs_pkg.sv
package kvs_pkg;

  localparam int KEYS    = 64;
  localparam int AW      = $clog2(KEYS);
  localparam int CNT_W   = $clog2(KEYS + 1);
  localparam int FRAME_W = 16;
  localparam int TFRAC_W = 8;
  localparam int TIME_W  = FRAME_W + TFRAC_W;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = (VAL_W + 1) + (FRAC_W + 1);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [2:0][VAL_W-1:0] vec_t;

  typedef struct packed {
    logic                     kind;
    logic [TIME_W-1:0]        frame_time;
    logic signed [VAL_W-1:0]  value_x;
    logic signed [VAL_W-1:0]  value_y;
    logic signed [VAL_W-1:0]  value_z;
  } item_t;

  typedef struct packed {
    logic                     status;
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic signed [VAL_W-1:0]  out_z;
  } result_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    vec_t               vec;
  } entry_t;

endpackage

### sv/keyframe_vec3_sampler_top.sv
// A load appends its key at its transfer, or is dropped with status FULL when the table is
// full; its result goes through the done state into the output register. A query scans the
// keys in append order, one key per cycle through the key memory, and stops at an exact
// match, before the first key or past the last key, or else interpolates with the bit-serial
// fraction divider and then a multiply and an add state per component on the shared
// 33 x 17 multiplier. A query on an empty table goes straight to the done state. The block
// works on one item at a time; a finished result sits in the output register, so the next
// item is taken while it waits.
module keyframe_vec3_sampler_top
  import kvs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;

  entry_t mem [KEYS];
  entry_t rdata;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  entry_t        wr_entry;

  logic [CNT_W-1:0]   count;
  logic [AW-1:0]      idx;
  logic [TIME_W-1:0]  t_reg;
  logic [FRAME_W-1:0] prev_frame;
  vec_t               prev_vec;
  vec_t               cur_vec;
  vec_t               res_vec;
  logic               res_status;
  logic [FRAC_W-1:0]  div_d;
  logic [FRAC_W-1:0]  div_rem;
  logic [FRAC_W-1:0]  div_q;
  logic [3:0]         div_step;
  logic [1:0]         comp;
  logic signed [PROD_W-1:0] prod;

  logic [TIME_W-1:0]  key_time;
  logic [TIME_W-1:0]  t_diff;
  logic               last_key;
  logic [FRAC_W:0]    div_trial;
  logic [FRAC_W:0]    div_sub;
  logic signed [VAL_W:0]    delta;
  logic signed [VAL_W+1:0]  blend_sum;
  logic                     accept;
  logic                     full;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign full       = (count == CNT_W'(KEYS));

  assign wr_en    = accept && (item.kind == KIND_LOAD) && !full;
  assign wr_entry = '{frame: item.frame_time[TIME_W-1:TFRAC_W],
                      vec: {item.value_z, item.value_y, item.value_x}};
  assign rd_addr  = (state == ST_SCAN) ? idx + AW'(1) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= wr_entry;
    end
    rdata <= mem[rd_addr];
  end

  assign key_time  = {rdata.frame, {TFRAC_W{1'b0}}};
  assign t_diff    = t_reg - {prev_frame, {TFRAC_W{1'b0}}};
  assign last_key  = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign div_trial = {div_rem, div_q[FRAC_W-1]};
  assign div_sub   = div_trial - {1'b0, div_d};
  assign delta     = $signed({cur_vec[comp][VAL_W-1], cur_vec[comp]})
                   - $signed({prev_vec[comp][VAL_W-1], prev_vec[comp]});
  assign blend_sum = $signed({{2{prev_vec[comp][VAL_W-1]}}, prev_vec[comp]})
                   + prod[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            t_reg      <= item.frame_time;
            res_vec    <= '0;
            res_status <= STATUS_DONE;
            idx        <= '0;
            state      <= ST_DONE;
            if (item.kind == KIND_LOAD) begin
              if (full) begin
                res_status <= STATUS_FULL;
              end else begin
                count <= count + CNT_W'(1);
              end
            end else if (count != '0) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (key_time == t_reg) begin
            res_vec <= rdata.vec;
            state   <= ST_DONE;
          end else if (key_time > t_reg) begin
            if (idx == '0) begin
              res_vec <= rdata.vec;
              state   <= ST_DONE;
            end else begin
              cur_vec  <= rdata.vec;
              div_d    <= rdata.frame - prev_frame;
              div_rem  <= t_diff[TIME_W-1:TFRAC_W];
              div_q    <= {t_diff[TFRAC_W-1:0], {TFRAC_W{1'b0}}};
              div_step <= '0;
              state    <= ST_DIV;
            end
          end else begin
            prev_frame <= rdata.frame;
            prev_vec   <= rdata.vec;
            if (last_key) begin
              res_vec <= rdata.vec;
              state   <= ST_DONE;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        ST_DIV: begin
          if (!div_sub[FRAC_W]) begin
            div_rem <= div_sub[FRAC_W-1:0];
            div_q   <= {div_q[FRAC_W-2:0], 1'b1};
          end else begin
            div_rem <= div_trial[FRAC_W-1:0];
            div_q   <= {div_q[FRAC_W-2:0], 1'b0};
          end
          div_step <= div_step + 4'd1;
          if (div_step == 4'd15) begin
            comp  <= 2'd0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= delta * $signed({1'b0, div_q});
          state <= ST_ADD;
        end
        ST_ADD: begin
          res_vec[comp] <= blend_sum[VAL_W-1:0];
          if (comp == 2'd2) begin
            state <= ST_DONE;
          end else begin
            comp  <= comp + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            result       <= '{status: res_status, out_x: res_vec[0],
                              out_y: res_vec[1], out_z: res_vec[2]};
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/kvs_checker.sv
module kvs_checker
  import kvs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A stalled result keeps its payload until the transfer.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // One item at a time: after an input transfer the block stops taking items.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken while busy");

  // A new result appears only when the block has been busy with an item.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result without work");

  // A dropped key reports a zero vector.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == STATUS_FULL) |->
      (result.out_x == '0) && (result.out_y == '0) && (result.out_z == '0))
    else $error("full status with nonzero vector");

endmodule

bind keyframe_vec3_sampler_top kvs_checker u_kvs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

### verif/tb_keyframe_vec3_sampler_top.sv
`timescale 1ns / 100ps

module tb_keyframe_vec3_sampler_top
  import kvs_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 100;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  keyframe_vec3_sampler_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Shadow copy of the keyframe table.
  int           shadow_key_count = 0;
  logic [15:0]  shadow_frames [KEYS];
  vec_t         shadow_vecs [KEYS];

  result_t      expected_results [$];
  logic [15:0]  known_frames [$];

  int error_count    = 0;
  int items_sent     = 0;
  int loads_sent     = 0;
  int results_seen   = 0;
  int interp_count   = 0;
  int full_drops     = 0;
  int idle_cycles    = 0;
  int frame_cursor   = 400;
  int send_idle_pct  = 38;
  int recv_idle_pct  = 38;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] blend_component(logic [31:0] v0, logic [31:0] v1,
                                                  longint unsigned frac);
    longint s0;
    longint s1;
    longint sum;
    longint shifted;
    s0 = $signed(v0);
    s1 = $signed(v1);
    sum = s0 * (64'sd65536 - longint'(frac)) + s1 * longint'(frac);
    shifted = sum >>> 16;
    return shifted[31:0];
  endfunction

  function automatic result_t predict_keyframe_item(item_t it);
    result_t         r;
    logic            found;
    int unsigned     t;
    int unsigned     f1;
    longint unsigned f0;
    longint unsigned span;
    longint unsigned frac;
    vec_t            v;
    r = '0;
    r.status = STATUS_DONE;
    v = '0;
    t = 32'(it.frame_time);
    if (it.kind == KIND_LOAD) begin
      if (shadow_key_count >= KEYS) begin
        r.status = STATUS_FULL;
        full_drops++;
      end else begin
        shadow_frames[shadow_key_count] = it.frame_time[TIME_W-1:TFRAC_W];
        shadow_vecs[shadow_key_count] = {it.value_z, it.value_y, it.value_x};
        shadow_key_count++;
      end
    end else if (shadow_key_count > 0) begin
      found = 1'b0;
      for (int k = 0; k < shadow_key_count && !found; k++) begin
        f1 = int'(shadow_frames[k]) * 256;
        if (f1 == t) begin
          v = shadow_vecs[k];
          found = 1'b1;
        end else if (f1 > t) begin
          if (k == 0) begin
            v = shadow_vecs[0];
          end else begin
            f0 = 64'(shadow_frames[k-1]);
            span = longint'(shadow_frames[k]) - f0;
            frac = 0;
            if (span != 0 && t >= f0 * 256) begin
              frac = ((longint'(t) - f0 * 256) * 256) / span;
              if (frac > 65535) frac = 65535;
            end
            for (int c = 0; c < 3; c++) begin
              v[c] = blend_component(shadow_vecs[k-1][c], shadow_vecs[k][c], frac);
            end
            interp_count++;
          end
          found = 1'b1;
        end
      end
      if (!found) v = shadow_vecs[shadow_key_count-1];
      r.out_x = v[0];
      r.out_y = v[1];
      r.out_z = v[2];
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        expected_results = {expected_results, predict_keyframe_item(item)};
      end
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: status %0d out_x %0d", result.status,
                 result.out_x);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            error_count++;
          end
          if (result.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, result.out_x);
            error_count++;
          end
          if (result.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, result.out_y);
            error_count++;
          end
          if (result.out_z !== want.out_z) begin
            $error("out_z: expected %0d, got %0d", want.out_z, result.out_z);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_query_time();
    int sel;
    int t;
    sel = $urandom_range(99);
    if (known_frames.size() == 0 || sel < 8) begin
      t = $urandom_range(24'hFF_FFFF);
    end else if (sel < 30) begin
      t = int'(known_frames[$urandom_range(known_frames.size() - 1)]) * 256;
    end else if (sel < 50) begin
      t = int'(known_frames[$urandom_range(known_frames.size() - 1)]) * 256
          + int'($urandom_range(1200)) - 600;
    end else if (sel < 92) begin
      t = $urandom_range((frame_cursor + 8) * 256);
    end else begin
      t = $urandom_range(1) ? 24'hFF_FFFF : 0;
    end
    if (t < 0) t = 0;
    if (t > 24'hFF_FFFF) t = 24'hFF_FFFF;
    return t[TIME_W-1:0];
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    if (it.kind == KIND_LOAD) loads_sent++;
  endtask

  task automatic send_load(input logic [15:0] frame, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z);
    item_t it;
    it.kind = KIND_LOAD;
    it.frame_time = {frame, 8'($urandom)};
    it.value_x = x;
    it.value_y = y;
    it.value_z = z;
    if (loads_sent < KEYS) known_frames = {known_frames, frame};
    send_item(it);
  endtask

  task automatic send_query(input logic [TIME_W-1:0] t);
    item_t it;
    it.kind = KIND_QUERY;
    it.frame_time = t;
    it.value_x = $urandom;
    it.value_y = $urandom;
    it.value_z = $urandom;
    send_item(it);
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_query(24'h00_0000);
    send_query(24'hFF_FFFF);
  endtask

  task automatic test_first_keys();
    send_load(16'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_query({16'd50, 8'h00});
    send_query({16'd100, 8'h00});
    send_query(24'hFF_FFFF);
    send_load(16'd200, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_query({16'd150, 8'h80});
    send_query({16'd100, 8'h01});
    send_query({16'd200, 8'h00} - 24'd1);
    send_load(16'd150, pick_value(), pick_value(), pick_value());
    send_query({16'd180, 8'h00});
    send_query({16'd250, 8'h00});
    send_load(16'd300, pick_value(), pick_value(), pick_value());
    send_query({16'd250, 8'h00});
    send_query({16'd300, 8'h00});
    send_load(16'd300, pick_value(), pick_value(), pick_value());
    send_query(24'h00_0000);
    send_load(16'd0, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000);
    send_query({16'd350, 8'h00});
  endtask

  task automatic test_fill_table();
    logic [15:0] frame;
    while (loads_sent < KEYS - 1) begin
      repeat ($urandom_range(5)) send_query(pick_query_time());
      if ($urandom_range(9) == 0) begin
        frame = 16'($urandom_range(frame_cursor));
      end else begin
        frame_cursor += $urandom_range(1, 1000);
        if (frame_cursor > 65000) frame_cursor = 65000;
        frame = 16'(frame_cursor);
      end
      send_load(frame, pick_value(), pick_value(), pick_value());
    end
  endtask

  task automatic test_full_table();
    send_load(16'hFFFF, pick_value(), pick_value(), pick_value());
    send_query(24'hFF_FFFF);
    send_query(24'hFF_FF00);
    send_query(24'hFF_FEFF);
    send_load(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_load(16'h0000, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_random_queries(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) send_load(16'($urandom), $urandom, $urandom, $urandom);
      else send_query(pick_query_time());
    end
  endtask

  task automatic test_drain_pause();
    repeat (5) send_query(pick_query_time());
    wait_for_results();
    repeat (5) send_query(pick_query_time());
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_queries(120);
    send_idle_pct = 38;
    recv_idle_pct = 38;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_first_keys();
    test_fill_table();
    test_full_table();
    test_random_queries(250);
    test_drain_pause();
    test_random_queries(250);
    test_no_idle();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("Sent %0d items (%0d loads, %0d dropped on a full table), checked %0d results.",
             items_sent, loads_sent, full_drops, results_seen);
    $display("Queries covered an empty table, exact hits, edges and %0d interpolations.",
             interp_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
